// ===== sv/dtt_pkg.sv =====
// Package: shared constants, step-unit status type and period decode for the timer block.
package dtt_pkg;

    localparam int DIVIDER_BITS_DEF = 16;
    localparam int PHASE_W          = 11;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [15:0] ADDR_DIVIDER = 16'hFF04;
    localparam logic [15:0] ADDR_COUNTER = 16'hFF05;
    localparam logic [15:0] ADDR_MODULO  = 16'hFF06;
    localparam logic [15:0] ADDR_CONTROL = 16'hFF07;

    localparam logic [7:0] CTRL_READ_SET = 8'hF8;
    localparam logic [7:0] UNMAPPED_READ = 8'hFF;
    localparam logic [7:0] COUNTER_TOP   = 8'hFF;
    localparam int         ENABLE_IDX    = 2;

    // Status of one pass through the step unit.
    typedef struct packed {
        logic more;   // a whole period is still held in the accumulator
        logic wrap;   // this step reloads the counter
    } step_res_t;

    function automatic logic [PHASE_W-1:0] period_of(input logic [1:0] sel);
        logic [PHASE_W-1:0] p;
        unique case (sel)
            2'd1:    p = PHASE_W'(16);
            2'd2:    p = PHASE_W'(64);
            2'd3:    p = PHASE_W'(256);
            default: p = PHASE_W'(1024);
        endcase
        return p;
    endfunction

endpackage

// ===== sv/dtt_ifs.sv =====
// Interfaces: request and response channels of the timer block.
interface dtt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  cycles;
    logic [15:0] address;
    logic [7:0]  write_value;

    modport source (output valid, command, cycles, address, write_value, input ready);
    modport sink   (input valid, command, cycles, address, write_value, output ready);
endinterface

interface dtt_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       timer_irq;

    modport source (output valid, read_data, timer_irq, input ready);
    modport sink   (input valid, read_data, timer_irq, output ready);
endinterface

// ===== sv/div_tima_programmable_timer.sv =====
// Top level: divider and programmable counter peripheral with bus register access.
//
//  channel | role   | word contents
//  --------+--------+-----------------------------------------------
//  req     | sink   | command, cycles, address, write_value
//  rsp     | source | read_data, timer_irq
//
// Sequencing: a read, a write, an unknown command or a tick with the counter
//   disabled goes from idle straight to the done state. An enabled tick
//   first steps off N periods, N being the number of whole periods in phase +
//   cycles; the step unit retires one period per cycle (up to 79 at period 16).
// Reset: asynchronous, active low; clears every register to zero.
// Stalls: req.ready is high only while idle. A finished word waits in the
//   output register, so the next request is taken while rsp is stalled.
module div_tima_programmable_timer #(
    parameter int DIVIDER_BITS = dtt_pkg::DIVIDER_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dtt_req_if.sink    req,
    dtt_rsp_if.source  rsp
);
    import dtt_pkg::*;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;  // wait for a request word
    localparam logic [1:0] ST_STEP = 2'd1;  // retire periods one per cycle
    localparam logic [1:0] ST_DONE = 2'd2;  // hand the result to the output register

    logic [1:0]              state_reg,   state_next;
    logic [DIVIDER_BITS-1:0] divider_reg, divider_next;
    logic [PHASE_W-1:0]      phase_reg,   phase_next;
    logic [PHASE_W-1:0]      acc_reg,     acc_next;
    logic [PHASE_W-1:0]      period_reg,  period_next;
    logic [7:0]              counter_reg, counter_next;
    logic [7:0]              reload_reg,  reload_next;
    logic [2:0]              control_reg, control_next;
    logic [7:0]              res_data_reg, res_data_next;
    logic                    res_irq_reg,  res_irq_next;
    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              out_data_reg,  out_data_next;
    logic                    out_irq_reg,   out_irq_next;

    logic               accept;
    logic               wr_counter;
    logic [PHASE_W-1:0] step_acc;
    logic [7:0]         step_counter;
    step_res_t          step_res;

    assign req.ready     = (state_reg == ST_IDLE);
    assign accept        = req.valid && req.ready;
    assign wr_counter    = accept && (req.command == CMD_WRITE) &&
                           (req.address == ADDR_COUNTER);
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.timer_irq = out_irq_reg;

    dtt_step_unit u_step (
        .acc         (acc_reg),
        .period      (period_reg),
        .counter     (counter_reg),
        .reload      (reload_reg),
        .acc_out     (step_acc),
        .counter_out (step_counter),
        .res         (step_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        divider_next   = divider_reg;
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        period_next    = period_reg;
        counter_next   = counter_reg;
        reload_next    = reload_reg;
        control_next   = control_reg;
        res_data_next  = res_data_reg;
        res_irq_next   = res_irq_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_irq_next   = out_irq_reg;

        // Drop the output word once it is taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_data_next = '0;
                    res_irq_next  = 1'b0;
                    state_next    = ST_DONE;
                    unique case (req.command)
                        CMD_TICK:
                        begin
                            divider_next = divider_reg + DIVIDER_BITS'(req.cycles);
                            // Load the accumulator; the step unit walks off whole periods
                            if (control_reg[ENABLE_IDX])
                            begin
                                acc_next    = phase_reg + PHASE_W'(req.cycles);
                                period_next = period_of(control_reg[1:0]);
                                state_next  = ST_STEP;
                            end
                        end
                        CMD_READ:
                        begin
                            unique case (req.address)
                                ADDR_DIVIDER: res_data_next = divider_reg[15:8];
                                ADDR_COUNTER: res_data_next = counter_reg;
                                ADDR_MODULO:  res_data_next = reload_reg;
                                ADDR_CONTROL: res_data_next = CTRL_READ_SET |
                                                              {5'd0, control_reg};
                                default:      res_data_next = UNMAPPED_READ;
                            endcase
                        end
                        CMD_WRITE:
                        begin
                            unique case (req.address)
                                ADDR_DIVIDER: divider_next = '0;
                                ADDR_COUNTER: counter_next = req.write_value;
                                ADDR_MODULO:  reload_next  = req.write_value;
                                ADDR_CONTROL: control_next = req.write_value[2:0];
                                default:      ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            ST_STEP:
            begin
                if (step_res.more)
                begin
                    acc_next     = step_acc;
                    counter_next = step_counter;
                    if (step_res.wrap)
                    begin
                        res_irq_next = 1'b1;
                    end
                end
                else
                begin
                    phase_next = acc_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_data_reg;
                    out_irq_next   = res_irq_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            divider_reg   <= '0;
            phase_reg     <= '0;
            acc_reg       <= '0;
            period_reg    <= '0;
            counter_reg   <= '0;
            reload_reg    <= '0;
            control_reg   <= '0;
            res_data_reg  <= '0;
            res_irq_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_irq_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            divider_reg   <= divider_next;
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            period_reg    <= period_next;
            counter_reg   <= counter_next;
            reload_reg    <= reload_next;
            control_reg   <= control_next;
            res_data_reg  <= res_data_next;
            res_irq_reg   <= res_irq_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_irq_reg   <= out_irq_next;
        end
    end

`ifndef SYNTHESIS
    // Phase stays below the longest period between ticks
    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> phase_reg < PHASE_W'(1024))
        else $error("phase accumulator out of range");

    // Accumulator never exceeds the largest load
    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STEP |-> acc_reg <= PHASE_W'(1278))
        else $error("accumulator exceeds largest load");

    // Counter moves only by a step or by a bus write
    a_counter_src: assert property (@(posedge clk) disable iff (!rst_n)
        counter_reg != $past(counter_reg) |->
            ($past(state_reg) == ST_STEP || $past(wr_counter)))
        else $error("counter changed without step or write");

    // A word with read data never carries an interrupt
    a_read_no_irq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg != 8'd0) |-> !out_irq_reg)
        else $error("read word carries interrupt");
`endif

endmodule

// ===== sv/dtt_step_unit.sv =====
// Step unit: one period compare/subtract and one counter advance with reload.
module dtt_step_unit (
    input  logic [dtt_pkg::PHASE_W-1:0] acc,
    input  logic [dtt_pkg::PHASE_W-1:0] period,
    input  logic [7:0]                  counter,
    input  logic [7:0]                  reload,
    output logic [dtt_pkg::PHASE_W-1:0] acc_out,
    output logic [7:0]                  counter_out,
    output dtt_pkg::step_res_t          res
);
    import dtt_pkg::*;

    always_comb
    begin
        res.more    = (acc >= period);
        res.wrap    = res.more && (counter == COUNTER_TOP);
        acc_out     = acc - period;
        counter_out = res.wrap ? reload : counter + 8'd1;
    end

endmodule
